// ===== src/zsr_pkg.sv =====
// ----------------------------------------------------------------------------
// zsr_pkg: shared types and constants of the screen line renderer
// Holds the video memory geometry, the cell record handed from the fetch
// sequencer to the pixel stage, and the fixed 16-bit palette.
// ----------------------------------------------------------------------------
package zsr_pkg;

    localparam int unsigned VRAM_DEPTH = 6912;
    localparam int unsigned VRAM_AW    = 13;
    localparam int unsigned VRAM_DW    = 8;
    localparam int unsigned LINE_COUNT = 192;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    // Normal palette components.
    localparam logic [15:0] NORM_BLUE   = 16'hF000;
    localparam logic [15:0] NORM_RED    = 16'h07C0;
    localparam logic [15:0] NORM_GREEN  = 16'h001E;
    // Bright palette components.
    localparam logic [15:0] BRIGHT_BLUE  = 16'hF800;
    localparam logic [15:0] BRIGHT_RED   = 16'h07E0;
    localparam logic [15:0] BRIGHT_GREEN = 16'h001F;

    // One character cell of a line: bitmap byte, attribute byte, position, flash phase.
    typedef struct packed {
        logic [7:0] bits;
        logic [7:0] attr;
        logic [4:0] cell_idx;
        logic       flash;
    } cell_t;

    // Color number: bit 0 blue, bit 1 red, bit 2 green.
    function automatic logic [15:0] palette(input logic [2:0] color, input logic bright);
        logic [15:0] pix;
        pix = 16'h0000;
        if (bright) begin
            if (color[0]) pix = pix | BRIGHT_BLUE;
            if (color[1]) pix = pix | BRIGHT_RED;
            if (color[2]) pix = pix | BRIGHT_GREEN;
        end else begin
            if (color[0]) pix = pix | NORM_BLUE;
            if (color[1]) pix = pix | NORM_RED;
            if (color[2]) pix = pix | NORM_GREEN;
        end
        return pix;
    endfunction

endpackage

// ===== src/zsr_ram.sv =====
// ----------------------------------------------------------------------------
// zsr_ram: generic single-port synchronous RAM
// One access per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module zsr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/zsr_fetch.sv =====
// ----------------------------------------------------------------------------
// zsr_fetch: video memory read sequencer
// Issues the 64 reads of a line (bitmap byte then attribute byte for each of
// the 32 cells) and collects each cell into a one-entry hold buffer.
// ----------------------------------------------------------------------------
module zsr_fetch (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [7:0]                   line,
    input  logic                         flash,
    output logic [zsr_pkg::VRAM_AW-1:0]  rd_addr,
    input  logic [zsr_pkg::VRAM_DW-1:0]  rd_data,
    output logic                         hold_valid,
    output zsr_pkg::cell_t               hold,
    input  logic                         hold_pop,
    output logic                         busy
);

    logic                 run_reg;
    logic [5:0]           rd_cnt_reg;
    logic                 pend_reg;
    logic                 pend_attr_reg;
    logic [4:0]           pend_cell_reg;
    logic [7:0]           bmp_hi_reg;
    logic [4:0]           row_reg;
    logic                 flash_reg;
    logic [7:0]           bm_reg;
    logic                 hold_valid_reg;
    zsr_pkg::cell_t       hold_reg;
    logic                 issue;
    logic [4:0]           rd_cell;

    // An attribute read waits until the hold buffer is free, so its data
    // always has a place to land.
    assign issue   = run_reg && (!rd_cnt_reg[0] || !hold_valid_reg);
    assign rd_cell = rd_cnt_reg[5:1];
    assign rd_addr = rd_cnt_reg[0] ? {2'b11, 1'b0, row_reg, rd_cell} : {bmp_hi_reg, rd_cell};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg        <= 1'b0;
            rd_cnt_reg     <= 6'd0;
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (start) begin
                run_reg    <= 1'b1;
                rd_cnt_reg <= 6'd0;
            end else if (issue) begin
                rd_cnt_reg <= rd_cnt_reg + 6'd1;
                if (rd_cnt_reg == 6'd63) begin
                    run_reg <= 1'b0;
                end
            end
            pend_reg <= issue && !start;
            if (pend_reg && pend_attr_reg) begin
                hold_valid_reg <= 1'b1;
            end else if (hold_pop) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // Bitmap rows interleave: thirds, then pixel row, then char row.
            bmp_hi_reg <= {line[7:6], line[2:0], line[5:3]};
            row_reg    <= line[7:3];
            flash_reg  <= flash;
        end
        pend_attr_reg <= rd_cnt_reg[0];
        pend_cell_reg <= rd_cell;
        if (pend_reg && !pend_attr_reg) begin
            bm_reg <= rd_data;
        end
        if (pend_reg && pend_attr_reg) begin
            hold_reg.bits     <= bm_reg;
            hold_reg.attr     <= rd_data;
            hold_reg.cell_idx <= pend_cell_reg;
            hold_reg.flash    <= flash_reg;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold       = hold_reg;
    assign busy       = run_reg || pend_reg || hold_valid_reg;

endmodule

// ===== src/zsr_pixel.sv =====
// ----------------------------------------------------------------------------
// zsr_pixel: cell to pixel conversion and output register
// Turns one cell into two groups of four 16-bit pixels and presents them on
// the output stream through a registered stage.
// ----------------------------------------------------------------------------
module zsr_pixel (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           hold_valid,
    input  zsr_pkg::cell_t hold,
    output logic           hold_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [63:0]    out_pixels,
    output logic [5:0]     out_index,
    output logic           out_last
);

    logic           stage_valid_reg;
    zsr_pkg::cell_t stage_reg;
    logic           half_reg;
    logic           out_valid_reg;
    logic [63:0]    pixels_reg;
    logic [5:0]     index_reg;
    logic           last_reg;
    logic           out_load;
    logic [15:0]    ink;
    logic [15:0]    paper;
    logic [15:0]    ink_sw;
    logic [15:0]    paper_sw;
    logic [63:0]    group;
    logic [2:0]     col;

    assign out_load = stage_valid_reg && (!out_valid_reg || out_ready);
    assign hold_pop = hold_valid && (!stage_valid_reg || (out_load && half_reg));

    always_comb begin
        ink   = zsr_pkg::palette(stage_reg.attr[2:0], stage_reg.attr[6]);
        paper = zsr_pkg::palette(stage_reg.attr[5:3], stage_reg.attr[6]);
        if (stage_reg.attr[7] && stage_reg.flash) begin
            ink_sw   = paper;
            paper_sw = ink;
        end else begin
            ink_sw   = ink;
            paper_sw = paper;
        end
        group = 64'd0;
        col   = 3'd0;
        for (int p = 0; p < 4; p++) begin
            // Bit 7 of the bitmap byte is the leftmost pixel of the cell.
            col = ~{half_reg, 2'(p)};
            group[16*p +: 16] = stage_reg.bits[col] ? ink_sw : paper_sw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            half_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (hold_pop) begin
                stage_valid_reg <= 1'b1;
                half_reg        <= 1'b0;
            end else if (out_load) begin
                half_reg <= ~half_reg;
                if (half_reg) begin
                    stage_valid_reg <= 1'b0;
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_pop) begin
            stage_reg <= hold;
        end
        if (out_load) begin
            pixels_reg <= group;
            index_reg  <= {stage_reg.cell_idx, half_reg};
            last_reg   <= (stage_reg.cell_idx == 5'd31) && half_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixels = pixels_reg;
    assign out_index  = index_reg;
    assign out_last   = last_reg;

endmodule

// ===== src/zx_screen_line_renderer_core.sv =====
// ----------------------------------------------------------------------------
// zx_screen_line_renderer_core: display line renderer with video memory
// Holds the 6912-byte video memory and renders one display line into 64
// beats of four 16-bit pixels each.
// ----------------------------------------------------------------------------
// A write beat (tuser 0) stores one byte; writes at offset 6912 or above are
// dropped. A render beat (tuser 1) for line 0..191 streams 64 beats of four
// pixels, leftmost pixel in the low bits, and marks the last with tlast;
// lines 192 and above give nothing. Rendering is bound by the single memory
// port and the one-cell hold buffer: each cell needs a bitmap and an
// attribute read, and the attribute read waits until the previous cell has
// left the hold buffer. The first result beat follows the fetch of the first
// cell through the hold buffer, the pixel stage and the output register. The
// next input beat is taken once the last cell has moved to the pixel stage,
// while the final two result beats are still draining. Stalls on m_tready
// also stall the pixel stage and, through the hold buffer, the fetch.
module zx_screen_line_renderer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [12:0] vram_address, [20:13] write_data, [28:21] line_number,
    // [29] flash_phase, [31:30] zero
    input  logic [31:0] s_tdata,
    // [0] kind
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [63:0] pixel_group, [69:64] group_index, [71:70] zero
    output logic [71:0] m_tdata,
    output logic        m_tlast
);

    logic                        accept;
    logic                        ram_we;
    logic                        start;
    logic [zsr_pkg::VRAM_AW-1:0] ram_addr;
    logic [zsr_pkg::VRAM_AW-1:0] rd_addr;
    logic [zsr_pkg::VRAM_DW-1:0] rd_data;
    logic [zsr_pkg::VRAM_AW-1:0] s_addr;
    logic [7:0]                  s_line;
    logic                        busy;
    logic                        hold_valid;
    zsr_pkg::cell_t              hold;
    logic                        hold_pop;
    logic [63:0]                 pixels;
    logic [5:0]                  index;

    assign s_addr   = s_tdata[12:0];
    assign s_line   = s_tdata[28:21];
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;
    assign ram_we   = accept && (s_tuser == zsr_pkg::KIND_WRITE)
                      && (s_addr < zsr_pkg::VRAM_AW'(zsr_pkg::VRAM_DEPTH));
    assign start    = accept && (s_tuser == zsr_pkg::KIND_RENDER)
                      && (s_line < 8'(zsr_pkg::LINE_COUNT));
    assign ram_addr = ram_we ? s_addr : rd_addr;

    zsr_ram #(
        .WIDTH (zsr_pkg::VRAM_DW),
        .DEPTH (zsr_pkg::VRAM_DEPTH)
    ) u_vram (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata[20:13]),
        .rdata (rd_data)
    );

    zsr_fetch u_fetch (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .line       (s_line),
        .flash      (s_tdata[29]),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .hold_valid (hold_valid),
        .hold       (hold),
        .hold_pop   (hold_pop),
        .busy       (busy)
    );

    zsr_pixel u_pixel (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .hold_valid (hold_valid),
        .hold       (hold),
        .hold_pop   (hold_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixels (pixels),
        .out_index  (index),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, index, pixels};

endmodule
